/* rtl/pps_pkg.sv */
// Shared types, constants and helper function of the pure-pursuit steering block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package pps_pkg;

    // Default path store depth.
    localparam int PATH_DEPTH_DEF = 1024;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOKAHEAD_GAIN = 3'd0,
        CFG_LOOKAHEAD_BASE = 3'd1,
        CFG_WHEELBASE      = 3'd2,
        CFG_STEER_LIMIT    = 3'd3,
        CFG_TOP_SPEED      = 3'd4,
        CFG_SPEED_BLEND    = 3'd5,
        CFG_GOAL_RADIUS    = 3'd6,
        CFG_POINT_SPACING  = 3'd7
    } t_cfg_idx;

    // Configuration reset values.
    localparam logic [15:0] RST_LOOKAHEAD_GAIN = 16'd26;
    localparam logic [22:0] RST_LOOKAHEAD_BASE = 23'd22938;
    localparam logic [22:0] RST_WHEELBASE      = 23'd26214;
    localparam logic [13:0] RST_STEER_LIMIT    = 14'd4817;
    localparam logic [14:0] RST_TOP_SPEED      = 15'd205;
    localparam logic [16:0] RST_SPEED_BLEND    = 17'd52429;
    localparam logic [22:0] RST_GOAL_RADIUS    = 23'd32768;
    localparam logic [22:0] RST_POINT_SPACING  = 23'd6554;

    // Request types.
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_ODOM   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_DRIVE   = 3'd0,
        STAT_GOAL    = 3'd1,
        STAT_NO_PATH = 3'd2,
        STAT_STORED  = 3'd3,
        STAT_SKIPPED = 3'd4,
        STAT_FULL    = 3'd5
    } t_status;

    // Arithmetic widths.
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIST_W   = 66;
    localparam int CORDIC_W = 52;
    localparam int ANG_W    = 22;
    localparam int CNT_W    = 5;
    localparam int CORDIC_STEPS = 17;

    // Angle constants in Q.16 radians and the CORDIC gain inverse in Q.30.
    localparam logic signed [ANG_W-1:0]    PI16     = 22'sd205887;
    localparam logic signed [ANG_W-1:0]    TWOPI16  = 22'sd411775;
    localparam logic signed [ANG_W-1:0]    HALFPI16 = 22'sd102944;
    localparam logic signed [CORDIC_W-1:0] KINV30   = 52'sd652032875;

    // Arctangent of 2^-i in Q.16 radians.
    function automatic logic signed [ANG_W-1:0] cordic_angle(input logic [CNT_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 22'sd51472;
            5'd1:    a = 22'sd30385;
            5'd2:    a = 22'sd16055;
            5'd3:    a = 22'sd8150;
            5'd4:    a = 22'sd4091;
            5'd5:    a = 22'sd2047;
            5'd6:    a = 22'sd1024;
            5'd7:    a = 22'sd512;
            5'd8:    a = 22'sd256;
            5'd9:    a = 22'sd128;
            5'd10:   a = 22'sd64;
            5'd11:   a = 22'sd32;
            5'd12:   a = 22'sd16;
            5'd13:   a = 22'sd8;
            5'd14:   a = 22'sd4;
            5'd15:   a = 22'sd2;
            5'd16:   a = 22'sd1;
            default: a = 22'sd0;
        endcase
        return a;
    endfunction

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_DIFF_LAST,
        DP_DIFF_POS,
        DP_DIFF_NEAR,
        DP_SQ_DX,
        DP_SQ_DY,
        DP_SUM,
        DP_SQ_SPACE,
        DP_SQ_GOAL,
        DP_SQ_LF,
        DP_STORE,
        DP_CLEAR,
        DP_ODO_INIT,
        DP_RD,
        DP_BEST_UPD,
        DP_NEAR_SET,
        DP_NEAR_LATCH,
        DP_LF_MUL,
        DP_LF_ADD,
        DP_TGT_TST,
        DP_TGT_CLAMP,
        DP_GOAL_CHK,
        DP_IDX_TGT,
        DP_CV_INIT_A,
        DP_CV_INIT_S,
        DP_VEC_STEP,
        DP_ALPHA,
        DP_ROT_STEP,
        DP_WB_MUL,
        DP_DELTA,
        DP_EMIT
    } t_dp_op;

    // Blend steps drive the shared multiplier through this separate command field.
    typedef enum logic [1:0] {
        BL_NONE,
        BL_MEAS,
        BL_TOP,
        BL_SUM
    } t_blend_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_dp_op    op;
        t_blend_op blend;
        t_status   emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req req;
        logic count_zero;
        logic count_full;
        logic d_le_ref;
        logic d_gt_ref;
        logic idx_end;
        logic cor_last;
        logic goal;
        logic out_busy;
    } t_dp_status;

    // Controller states.
    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH,
        S_A_DIFF, S_A_SQX, S_A_SQY, S_A_SUM, S_A_SQSP, S_A_CHK, S_A_STORE,
        S_CLEAR,
        S_O_INIT, S_P1_HEAD, S_P1_RD, S_P1_DIFF, S_P1_SQX, S_P1_SQY, S_P1_SUM, S_P1_UPD,
        S_N_SET, S_N_RD, S_N_LATCH, S_LF_MUL, S_LF_ADD, S_LF_SQ,
        S_P2_HEAD, S_P2_RD, S_P2_DIFF, S_P2_SQX, S_P2_SQY, S_P2_SUM, S_P2_TST,
        S_T_CLAMP, S_G_RD, S_G_DIFF, S_G_SQX, S_G_SQY, S_G_SUM, S_G_SQ, S_G_CHK,
        S_T_IDX, S_T_RD, S_T_DIFF, S_V1_INIT, S_V1_STEP, S_ALPHA, S_R_STEP,
        S_WB_MUL, S_V2_INIT, S_V2_STEP, S_DELTA, S_BL1, S_BL2, S_BL3, S_EMIT
    } t_state;

endpackage

/* rtl/pps_req_if.sv */
// Request channel interface of the pure-pursuit steering block.
// Depends on pps_pkg.
interface pps_req_if import pps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] speed;

    modport source(output valid, output req_type, output pos_x, output pos_y,
                   output heading, output speed, input ready);
    modport sink(input valid, input req_type, input pos_x, input pos_y,
                 input heading, input speed, output ready);
endinterface

/* rtl/pps_res_if.sv */
// Result channel interface of the pure-pursuit steering block.
// Depends on pps_pkg.
interface pps_res_if import pps_pkg::*;;
    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [14:0] steer_cmd;
    logic signed [15:0] speed_cmd;
    logic [9:0]         nearest_index;
    logic [9:0]         aim_index;
    logic [10:0]        path_length;

    modport source(output valid, output status, output steer_cmd, output speed_cmd,
                   output nearest_index, output aim_index, output path_length,
                   input ready);
    modport sink(input valid, input status, input steer_cmd, input speed_cmd,
                 input nearest_index, input aim_index, input path_length,
                 output ready);
endinterface

/* rtl/pps_dp.sv */
// Datapath of the pure-pursuit steering block: path store, configuration registers,
// shared multiplier, distance compare, shared CORDIC and the result register.
// Depends on pps_pkg and pps_res_if.
module pps_dp import pps_pkg::*; #(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_req_type,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [15:0]    i_heading,
    input  logic signed [15:0]    i_speed,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_stat,
    pps_res_if.source             o_res
);

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);

    // Configuration registers.
    logic [15:0] r_gain;
    logic [22:0] r_base;
    logic [22:0] r_wb;
    logic [13:0] r_lim;
    logic [14:0] r_top;
    logic [16:0] r_blend;
    logic [22:0] r_goalr;
    logic [22:0] r_space;

    // Path store.
    logic signed [31:0] mem_x [PATH_DEPTH];
    logic signed [31:0] mem_y [PATH_DEPTH];

    // Item and path state.
    logic [1:0]         r_req;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_head, r_spd;
    logic [CW-1:0]      r_count, r_start, r_idx, r_near, r_tgt;
    logic signed [31:0] r_lastx, r_lasty;
    logic               r_first;
    logic signed [31:0] r_mx, r_my, r_nx, r_ny;
    logic signed [32:0] r_dx, r_dy;
    logic signed [PROD_W-1:0] r_acc, r_prod;
    logic [DIST_W-1:0]  r_dist, r_ref, r_best;
    logic [31:0]        r_lf;
    logic               r_goal;

    // CORDIC state.
    logic signed [CORDIC_W-1:0] r_cx, r_cy;
    logic signed [ANG_W-1:0]    r_cz;
    logic                       r_czero;
    logic [CNT_W-1:0]           r_cnt;

    logic signed [14:0] r_steer;
    logic signed [15:0] r_speed;

    // Result register.
    logic               r_ov;
    t_status            r_ost;
    logic signed [14:0] r_osteer;
    logic signed [15:0] r_ospeed;
    logic [9:0]         r_onear, r_otgt;
    logic [10:0]        r_olen;

    // Combinational signals.
    logic [32:0]              mag_dx, mag_dy;
    logic [16:0]              kv, kv_c;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [33:0]       lf_sum;
    logic signed [PROD_W-1:0] bl_sum, bl_q;
    logic signed [15:0]       bl_sat;
    logic signed [CORDIC_W-1:0] src_x, src_y, xs, ys;
    logic signed [ANG_W-1:0]  ang, zres, a0, a1, f1, dq, lim_s, dcl;
    logic [CW-1:0]            last_idx;
    logic                     emit_drive, emit_idx;

    assign last_idx = r_count - CW'(1);
    assign mag_dx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign mag_dy = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign kv     = (r_blend > 17'd65536) ? 17'd65536 : r_blend;
    assign kv_c   = 17'd65536 - kv;

    assign emit_drive = (i_cmd.emit == STAT_DRIVE);
    assign emit_idx   = (i_cmd.emit == STAT_DRIVE) || (i_cmd.emit == STAT_GOAL);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            DP_SQ_DX: begin
                mul_a = {1'b0, mag_dx};
                mul_b = {1'b0, mag_dx};
            end
            DP_SQ_DY: begin
                mul_a = {1'b0, mag_dy};
                mul_b = {1'b0, mag_dy};
            end
            DP_SQ_SPACE: begin
                mul_a = {11'b0, r_space};
                mul_b = {11'b0, r_space};
            end
            DP_SQ_GOAL: begin
                mul_a = {11'b0, r_goalr};
                mul_b = {11'b0, r_goalr};
            end
            DP_SQ_LF: begin
                mul_a = {2'b0, r_lf};
                mul_b = {2'b0, r_lf};
            end
            DP_LF_MUL: begin
                mul_a = {18'b0, r_gain};
                mul_b = {{18{r_spd[15]}}, r_spd};
            end
            DP_WB_MUL: begin
                mul_a = {11'b0, r_wb};
                mul_b = r_cy[MUL_W-1:0];
            end
            default: begin
                case (i_cmd.blend)
                    BL_MEAS: begin
                        mul_a = {17'b0, kv};
                        mul_b = {{18{r_spd[15]}}, r_spd};
                    end
                    BL_TOP: begin
                        mul_a = {17'b0, kv_c};
                        mul_b = {19'b0, r_top};
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Lookahead distance with a one-LSB floor.
    assign lf_sum = $signed(r_prod[33:0]) + $signed({11'b0, r_base});

    // Speed blend with rounding and saturation.
    assign bl_sum = r_acc + r_prod + PROD_W'(32768);
    assign bl_q   = bl_sum >>> 16;
    always_comb begin
        if (bl_q > PROD_W'(32767)) begin
            bl_sat = 16'sh7FFF;
        end else if (bl_q < -PROD_W'(32768)) begin
            bl_sat = -16'sh8000;
        end else begin
            bl_sat = bl_q[15:0];
        end
    end

    // CORDIC start vector selection.
    always_comb begin
        if (i_cmd.op == DP_CV_INIT_S) begin
            src_x = {4'b0, r_lf, 16'b0};
            src_y = r_prod[13+CORDIC_W-1:13];
        end else begin
            src_x = {{(CORDIC_W-33){r_dx[32]}}, r_dx};
            src_y = {{(CORDIC_W-33){r_dy[32]}}, r_dy};
        end
    end

    assign xs   = r_cx >>> r_cnt;
    assign ys   = r_cy >>> r_cnt;
    assign ang  = cordic_angle(r_cnt);
    assign zres = r_czero ? '0 : r_cz;

    // Bearing minus heading, wrapped once, then folded into the sine range.
    always_comb begin
        a0 = zres - ({{(ANG_W-16){r_head[15]}}, r_head} <<< 3);
        if (a0 > PI16) begin
            a1 = a0 - TWOPI16;
        end else if (a0 < -PI16) begin
            a1 = a0 + TWOPI16;
        end else begin
            a1 = a0;
        end
        f1 = a1;
        if (f1 > HALFPI16) begin
            f1 = PI16 - f1;
        end
        if (f1 < -HALFPI16) begin
            f1 = -PI16 - f1;
        end
    end

    // Steering angle rounding to Q2.13 and clamp.
    assign dq    = (zres + ANG_W'(4)) >>> 3;
    assign lim_s = {{(ANG_W-14){1'b0}}, r_lim};
    always_comb begin
        if (dq > lim_s) begin
            dcl = lim_s;
        end else if (dq < -lim_s) begin
            dcl = -lim_s;
        end else begin
            dcl = dq;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.req        = t_req'(r_req);
        o_stat.count_zero = (r_count == '0);
        o_stat.count_full = (r_count >= CW'(PATH_DEPTH));
        o_stat.d_le_ref   = (r_dist <= r_ref);
        o_stat.d_gt_ref   = (r_dist > r_ref);
        o_stat.idx_end    = (r_idx >= r_count);
        o_stat.cor_last   = (r_cnt == CNT_W'(CORDIC_STEPS - 1));
        o_stat.goal       = r_goal;
        o_stat.out_busy   = r_ov && !o_res.ready;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= RST_LOOKAHEAD_GAIN;
            r_base  <= RST_LOOKAHEAD_BASE;
            r_wb    <= RST_WHEELBASE;
            r_lim   <= RST_STEER_LIMIT;
            r_top   <= RST_TOP_SPEED;
            r_blend <= RST_SPEED_BLEND;
            r_goalr <= RST_GOAL_RADIUS;
            r_space <= RST_POINT_SPACING;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOOKAHEAD_GAIN: r_gain  <= i_cfg_data[15:0];
                CFG_LOOKAHEAD_BASE: r_base  <= i_cfg_data;
                CFG_WHEELBASE:      r_wb    <= i_cfg_data;
                CFG_STEER_LIMIT:    r_lim   <= i_cfg_data[13:0];
                CFG_TOP_SPEED:      r_top   <= i_cfg_data[14:0];
                CFG_SPEED_BLEND:    r_blend <= i_cfg_data[16:0];
                CFG_GOAL_RADIUS:    r_goalr <= i_cfg_data;
                CFG_POINT_SPACING:  r_space <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Path store write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_STORE) begin
            mem_x[r_count[AW-1:0]] <= r_px;
            mem_y[r_count[AW-1:0]] <= r_py;
        end
        if (i_cmd.op == DP_RD) begin
            r_mx <= mem_x[r_idx[AW-1:0]];
            r_my <= mem_y[r_idx[AW-1:0]];
        end
    end

    // Path state and result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= '0;
            r_lastx <= '0;
            r_lasty <= '0;
            r_ov    <= 1'b0;
        end else begin
            // A new result is only loaded once the previous one has left.
            if (i_cmd.op == DP_EMIT) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.op)
                DP_STORE: begin
                    r_lastx <= r_px;
                    r_lasty <= r_py;
                    r_count <= r_count + CW'(1);
                end
                DP_CLEAR: begin
                    r_count <= '0;
                    r_start <= '0;
                end
                DP_NEAR_SET: r_start <= r_near;
                default: ;
            endcase
        end
    end

    // Working registers of the search, the arithmetic and the result payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_req  <= i_req_type;
                r_px   <= i_pos_x;
                r_py   <= i_pos_y;
                r_head <= i_heading;
                r_spd  <= i_speed;
            end
            DP_DIFF_LAST: begin
                r_dx <= {r_px[31], r_px} - {r_lastx[31], r_lastx};
                r_dy <= {r_py[31], r_py} - {r_lasty[31], r_lasty};
            end
            DP_DIFF_POS: begin
                r_dx <= {r_mx[31], r_mx} - {r_px[31], r_px};
                r_dy <= {r_my[31], r_my} - {r_py[31], r_py};
            end
            DP_DIFF_NEAR: begin
                r_dx <= {r_mx[31], r_mx} - {r_nx[31], r_nx};
                r_dy <= {r_my[31], r_my} - {r_ny[31], r_ny};
            end
            DP_SQ_DX:    r_acc <= mul_p;
            DP_SQ_DY:    r_prod <= mul_p;
            DP_SUM:      r_dist <= r_acc[DIST_W-1:0] + r_prod[DIST_W-1:0];
            DP_SQ_SPACE: r_ref <= mul_p[DIST_W-1:0];
            DP_SQ_GOAL:  r_ref <= mul_p[DIST_W-1:0];
            DP_SQ_LF:    r_ref <= mul_p[DIST_W-1:0];
            DP_ODO_INIT: begin
                r_idx   <= (r_start >= r_count) ? '0 : r_start;
                r_first <= 1'b1;
            end
            DP_BEST_UPD: begin
                if (r_first || (r_dist < r_best)) begin
                    r_best <= r_dist;
                    r_near <= r_idx;
                end
                r_first <= 1'b0;
                r_idx   <= r_idx + CW'(1);
            end
            DP_NEAR_SET: r_idx <= r_near;
            DP_NEAR_LATCH: begin
                r_nx  <= r_mx;
                r_ny  <= r_my;
                r_idx <= r_near + CW'(1);
                r_tgt <= r_near + CW'(1);
            end
            DP_LF_MUL: r_prod <= mul_p;
            DP_LF_ADD: r_lf <= (lf_sum < 34'sd1) ? 32'd1 : lf_sum[31:0];
            DP_TGT_TST: begin
                if (r_dist > r_ref) begin
                    r_tgt <= r_idx;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            DP_TGT_CLAMP: begin
                if (r_tgt > last_idx) begin
                    r_tgt <= last_idx;
                end
                r_idx <= last_idx;
            end
            DP_GOAL_CHK: r_goal <= (r_dist < r_ref);
            DP_IDX_TGT:  r_idx <= r_tgt;
            DP_CV_INIT_A, DP_CV_INIT_S: begin
                r_cnt   <= '0;
                r_czero <= (src_x == '0) && (src_y == '0);
                if (src_x < 0) begin
                    r_cz <= (src_y >= 0) ? PI16 : -PI16;
                    r_cx <= -src_x;
                    r_cy <= -src_y;
                end else begin
                    r_cz <= '0;
                    r_cx <= src_x;
                    r_cy <= src_y;
                end
            end
            DP_VEC_STEP: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cy > 0) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + ang;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - ang;
                end
            end
            DP_ALPHA: begin
                r_cx    <= KINV30;
                r_cy    <= '0;
                r_cz    <= f1;
                r_czero <= 1'b0;
                r_cnt   <= '0;
            end
            DP_ROT_STEP: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cz >= 0) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - ang;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + ang;
                end
            end
            DP_WB_MUL: r_prod <= mul_p;
            DP_DELTA:  r_steer <= dcl[14:0];
            DP_EMIT: begin
                // Commands only carry meaning for drive results, indices for drive and goal results.
                r_ost    <= i_cmd.emit;
                r_olen   <= 11'(r_count);
                r_osteer <= emit_drive ? r_steer : '0;
                r_ospeed <= emit_drive ? r_speed : '0;
                r_onear  <= emit_idx ? 10'(r_near) : '0;
                r_otgt   <= emit_idx ? 10'(r_tgt) : '0;
            end
            default: begin
                case (i_cmd.blend)
                    BL_MEAS: r_acc <= mul_p;
                    BL_TOP:  r_prod <= mul_p;
                    BL_SUM:  r_speed <= bl_sat;
                    default: ;
                endcase
            end
        endcase
    end

    // Result channel.
    assign o_res.valid         = r_ov;
    assign o_res.status        = r_ost;
    assign o_res.steer_cmd     = r_osteer;
    assign o_res.speed_cmd     = r_ospeed;
    assign o_res.nearest_index = r_onear;
    assign o_res.aim_index     = r_otgt;
    assign o_res.path_length   = r_olen;

endmodule

/* rtl/pps_ctrl.sv */
// Controller state machine of the pure-pursuit steering block.
// Sequences the datapath through append, clear and odometry work. Depends on pps_pkg.
module pps_ctrl import pps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd
);

    t_state  r_state, n_state;
    t_status r_emit, n_emit;

    // State and pending status code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= STAT_STORED;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_emit      = r_emit;
        o_cmd.op    = DP_NOP;
        o_cmd.blend = BL_NONE;
        o_cmd.emit  = r_emit;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.req)
                    REQ_APPEND: n_state = i_stat.count_zero ? S_A_STORE : S_A_DIFF;
                    REQ_CLEAR:  n_state = S_CLEAR;
                    REQ_ODOM: begin
                        if (i_stat.count_zero) begin
                            n_emit  = STAT_NO_PATH;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_O_INIT;
                        end
                    end
                    default: begin
                        n_emit  = STAT_SKIPPED;
                        n_state = S_EMIT;
                    end
                endcase
            end

            // Spacing test against the last kept point.
            S_A_DIFF: begin o_cmd.op = DP_DIFF_LAST; n_state = S_A_SQX; end
            S_A_SQX:  begin o_cmd.op = DP_SQ_DX;     n_state = S_A_SQY; end
            S_A_SQY:  begin o_cmd.op = DP_SQ_DY;     n_state = S_A_SUM; end
            S_A_SUM:  begin o_cmd.op = DP_SUM;       n_state = S_A_SQSP; end
            S_A_SQSP: begin o_cmd.op = DP_SQ_SPACE;  n_state = S_A_CHK; end
            S_A_CHK: begin
                if (i_stat.d_le_ref) begin
                    n_emit  = STAT_SKIPPED;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_A_STORE;
                end
            end
            S_A_STORE: begin
                if (i_stat.count_full) begin
                    n_emit = STAT_FULL;
                end else begin
                    o_cmd.op = DP_STORE;
                    n_emit   = STAT_STORED;
                end
                n_state = S_EMIT;
            end
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                n_emit   = STAT_STORED;
                n_state  = S_EMIT;
            end

            // First pass: nearest point from the search start.
            S_O_INIT:  begin o_cmd.op = DP_ODO_INIT; n_state = S_P1_HEAD; end
            S_P1_HEAD: n_state = i_stat.idx_end ? S_N_SET : S_P1_RD;
            S_P1_RD:   begin o_cmd.op = DP_RD;       n_state = S_P1_DIFF; end
            S_P1_DIFF: begin o_cmd.op = DP_DIFF_POS; n_state = S_P1_SQX; end
            S_P1_SQX:  begin o_cmd.op = DP_SQ_DX;    n_state = S_P1_SQY; end
            S_P1_SQY:  begin o_cmd.op = DP_SQ_DY;    n_state = S_P1_SUM; end
            S_P1_SUM:  begin o_cmd.op = DP_SUM;      n_state = S_P1_UPD; end
            S_P1_UPD:  begin o_cmd.op = DP_BEST_UPD; n_state = S_P1_HEAD; end

            // Nearest point and lookahead distance.
            S_N_SET:   begin o_cmd.op = DP_NEAR_SET;   n_state = S_N_RD; end
            S_N_RD:    begin o_cmd.op = DP_RD;         n_state = S_N_LATCH; end
            S_N_LATCH: begin o_cmd.op = DP_NEAR_LATCH; n_state = S_LF_MUL; end
            S_LF_MUL:  begin o_cmd.op = DP_LF_MUL;     n_state = S_LF_ADD; end
            S_LF_ADD:  begin o_cmd.op = DP_LF_ADD;     n_state = S_LF_SQ; end
            S_LF_SQ:   begin o_cmd.op = DP_SQ_LF;      n_state = S_P2_HEAD; end

            // Second pass: first point beyond the lookahead distance.
            S_P2_HEAD: n_state = i_stat.idx_end ? S_T_CLAMP : S_P2_RD;
            S_P2_RD:   begin o_cmd.op = DP_RD;        n_state = S_P2_DIFF; end
            S_P2_DIFF: begin o_cmd.op = DP_DIFF_NEAR; n_state = S_P2_SQX; end
            S_P2_SQX:  begin o_cmd.op = DP_SQ_DX;     n_state = S_P2_SQY; end
            S_P2_SQY:  begin o_cmd.op = DP_SQ_DY;     n_state = S_P2_SUM; end
            S_P2_SUM:  begin o_cmd.op = DP_SUM;       n_state = S_P2_TST; end
            S_P2_TST: begin
                o_cmd.op = DP_TGT_TST;
                n_state  = i_stat.d_gt_ref ? S_T_CLAMP : S_P2_HEAD;
            end

            // Target clamp, then goal test against the final point.
            S_T_CLAMP: begin o_cmd.op = DP_TGT_CLAMP; n_state = S_G_RD; end
            S_G_RD:    begin o_cmd.op = DP_RD;        n_state = S_G_DIFF; end
            S_G_DIFF:  begin o_cmd.op = DP_DIFF_POS;  n_state = S_G_SQX; end
            S_G_SQX:   begin o_cmd.op = DP_SQ_DX;     n_state = S_G_SQY; end
            S_G_SQY:   begin o_cmd.op = DP_SQ_DY;     n_state = S_G_SUM; end
            S_G_SUM:   begin o_cmd.op = DP_SUM;       n_state = S_G_SQ; end
            S_G_SQ:    begin o_cmd.op = DP_SQ_GOAL;   n_state = S_G_CHK; end
            S_G_CHK:   begin o_cmd.op = DP_GOAL_CHK;  n_state = S_T_IDX; end

            // Steering angle through the shared CORDIC.
            S_T_IDX:   begin o_cmd.op = DP_IDX_TGT;   n_state = S_T_RD; end
            S_T_RD:    begin o_cmd.op = DP_RD;        n_state = S_T_DIFF; end
            S_T_DIFF:  begin o_cmd.op = DP_DIFF_POS;  n_state = S_V1_INIT; end
            S_V1_INIT: begin o_cmd.op = DP_CV_INIT_A; n_state = S_V1_STEP; end
            S_V1_STEP: begin
                o_cmd.op = DP_VEC_STEP;
                if (i_stat.cor_last) begin
                    n_state = S_ALPHA;
                end
            end
            S_ALPHA:   begin o_cmd.op = DP_ALPHA;     n_state = S_R_STEP; end
            S_R_STEP: begin
                o_cmd.op = DP_ROT_STEP;
                if (i_stat.cor_last) begin
                    n_state = S_WB_MUL;
                end
            end
            S_WB_MUL:  begin o_cmd.op = DP_WB_MUL;    n_state = S_V2_INIT; end
            S_V2_INIT: begin o_cmd.op = DP_CV_INIT_S; n_state = S_V2_STEP; end
            S_V2_STEP: begin
                o_cmd.op = DP_VEC_STEP;
                if (i_stat.cor_last) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA:   begin o_cmd.op = DP_DELTA;     n_state = S_BL1; end

            // Speed blend.
            S_BL1: begin o_cmd.blend = BL_MEAS; n_state = S_BL2; end
            S_BL2: begin o_cmd.blend = BL_TOP;  n_state = S_BL3; end
            S_BL3: begin
                o_cmd.blend = BL_SUM;
                n_emit      = i_stat.goal ? STAT_GOAL : STAT_DRIVE;
                n_state     = S_EMIT;
            end

            // Hand the result to the output register once it is free.
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/pure_pursuit_steering.sv */
// Pure-pursuit steering block: stores a thinned path of points and, for each odometry
// item, finds the nearest and lookahead points and returns a clamped steering angle and
// a blended speed command. One item is worked on at a time. Both path walks read one
// stored point at a time through the single path-store read port and the shared
// multiplier, and the CORDIC runs 17 steps three times. Loading waits while the
// previous result is still held in the output register, and the next item can be
// accepted in the cycle after the result is loaded.
// Depends on pps_pkg, pps_req_if, pps_res_if, pps_ctrl and pps_dp.
module pure_pursuit_steering import pps_pkg::*; #(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pps_req_if.sink               i_req,
    pps_res_if.source             o_res
);

    t_dp_cmd    cmd;
    t_dp_status stat;
    logic       in_ready;

    assign i_req.ready = in_ready;

    // Sequencer.
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Path store and arithmetic.
    pps_dp #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req_type (i_req.req_type),
        .i_pos_x    (i_req.pos_x),
        .i_pos_y    (i_req.pos_y),
        .i_heading  (i_req.heading),
        .i_speed    (i_req.speed),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res)
    );

endmodule

/* tb/sv/pps_tb_checker.sv */
`timescale 1ns / 100ps
// Checker for the pure-pursuit steering block: watches the configuration port and both
// item channels, predicts every result and compares it with what the block returns.
// Depends on pps_pkg, pps_req_if and pps_res_if.
module pps_tb_checker import pps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pps_req_if                    req_ch,
    pps_res_if                    res_ch,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int DEPTH = PATH_DEPTH_DEF;
    localparam longint ANG_PI     = 205887;
    localparam longint ANG_TWO_PI = 411775;
    localparam longint ANG_HALF   = 102944;
    localparam longint GAIN_INV   = 652032875;
    localparam longint ATAN_STEP[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    typedef struct packed {
        t_status            status;
        logic signed [14:0] steer;
        logic signed [15:0] speed;
        logic [9:0]         near_idx;
        logic [9:0]         tgt_idx;
        logic [10:0]        len;
    } t_cmd_res;

    // Model state of the path store and the tracker.
    logic signed [31:0] path_x[DEPTH];
    logic signed [31:0] path_y[DEPTH];
    int unsigned        n_pts;
    int unsigned        seek_from;
    logic signed [31:0] kept_x, kept_y;

    // Model copy of the configuration registers.
    logic [15:0] r_gain;
    logic [22:0] r_base, r_wb, r_goal, r_space;
    logic [13:0] r_lim;
    logic [14:0] r_top;
    logic [16:0] r_blend;

    t_cmd_res cmd_q[$];
    t_cmd_res want;
    int       fail_n = 0;

    assign o_fail_count = fail_n;

    function automatic logic [127:0] sq_mag(input longint v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic logic [127:0] gap_sq(input longint ax, input longint ay,
                                            input longint bx, input longint by);
        return sq_mag(ax - bx) + sq_mag(ay - by);
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q.16 radians.
    function automatic longint cordic_angle_of(input longint y, input longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_STEP[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    // Rotation CORDIC: sine of a Q.16 angle in Q.30.
    function automatic longint cordic_sine(input longint z);
        longint x, y, xs, ys;
        x = GAIN_INV;
        y = 0;
        if (z > ANG_HALF) z = ANG_PI - z;
        if (z < -ANG_HALF) z = -ANG_PI - z;
        for (int i = 0; i < 17; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_STEP[i];
            end else begin
                x += ys; y -= xs; z += ATAN_STEP[i];
            end
        end
        return y;
    endfunction

    // Works out the result of one request and updates the model state.
    function automatic t_cmd_res predict_cmd(input t_req r, input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [15:0] hd,
                                             input logic signed [15:0] sp);
        t_cmd_res    res;
        logic [127:0] best, d, lf2;
        int unsigned near, tgt, last;
        longint      lf, alpha, s30, num, delta, kv, blend, cmd;
        res = '0;
        case (r)
            REQ_APPEND: begin
                if (n_pts > 0 && gap_sq(px, py, kept_x, kept_y) <= sq_mag(r_space)) begin
                    res.status = STAT_SKIPPED;
                end else if (n_pts >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    path_x[n_pts] = px;
                    path_y[n_pts] = py;
                    kept_x = px;
                    kept_y = py;
                    n_pts++;
                    res.status = STAT_STORED;
                end
            end
            REQ_CLEAR: begin
                n_pts = 0;
                seek_from = 0;
                res.status = STAT_STORED;
            end
            REQ_ODOM: begin
                if (n_pts == 0) begin
                    res.status = STAT_NO_PATH;
                end else begin
                    // Nearest point, lowest index on ties.
                    if (seek_from >= n_pts) seek_from = 0;
                    near = seek_from;
                    best = gap_sq(path_x[near], path_y[near], px, py);
                    for (int unsigned i = seek_from + 1; i < n_pts; i++) begin
                        d = gap_sq(path_x[i], path_y[i], px, py);
                        if (d < best) begin
                            best = d;
                            near = i;
                        end
                    end
                    seek_from = near;
                    last = n_pts - 1;

                    // Lookahead distance and target point.
                    lf = longint'(r_gain) * longint'(sp) + longint'(r_base);
                    if (lf < 1) lf = 1;
                    lf2 = sq_mag(lf);
                    tgt = near + 1;
                    for (int unsigned i = near + 1; i < n_pts; i++) begin
                        if (gap_sq(path_x[i], path_y[i], path_x[near], path_y[near]) > lf2)
                        begin
                            tgt = i;
                            break;
                        end
                    end
                    if (tgt > last) tgt = last;

                    // Steering angle.
                    alpha = cordic_angle_of(longint'(path_y[tgt]) - py,
                                            longint'(path_x[tgt]) - px) - longint'(hd) * 8;
                    if (alpha > ANG_PI) alpha -= ANG_TWO_PI;
                    else if (alpha < -ANG_PI) alpha += ANG_TWO_PI;
                    s30 = cordic_sine(alpha);
                    num = (2 * longint'(r_wb) * s30) >>> 14;
                    delta = (cordic_angle_of(num, lf * 65536) + 4) >>> 3;
                    if (delta > longint'(r_lim)) delta = r_lim;
                    if (delta < -longint'(r_lim)) delta = -longint'(r_lim);

                    // Speed blend with saturation.
                    kv = (r_blend > 17'd65536) ? 65536 : longint'(r_blend);
                    blend = kv * longint'(sp) + (65536 - kv) * longint'(r_top);
                    cmd = (blend + 32768) >>> 16;
                    if (cmd > 32767) cmd = 32767;
                    if (cmd < -32768) cmd = -32768;

                    res.near_idx = near[9:0];
                    res.tgt_idx = tgt[9:0];
                    if (gap_sq(px, py, path_x[last], path_y[last]) < sq_mag(r_goal)) begin
                        res.status = STAT_GOAL;
                    end else begin
                        res.status = STAT_DRIVE;
                        res.steer = delta[14:0];
                        res.speed = cmd[15:0];
                    end
                end
            end
            default: res.status = STAT_SKIPPED;
        endcase
        res.len = n_pts[10:0];
        return res;
    endfunction

    // Track configuration, predict each accepted request, check each accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_pts = 0;
            seek_from = 0;
            kept_x = '0;
            kept_y = '0;
            r_gain = RST_LOOKAHEAD_GAIN;
            r_base = RST_LOOKAHEAD_BASE;
            r_wb = RST_WHEELBASE;
            r_lim = RST_STEER_LIMIT;
            r_top = RST_TOP_SPEED;
            r_blend = RST_SPEED_BLEND;
            r_goal = RST_GOAL_RADIUS;
            r_space = RST_POINT_SPACING;
            cmd_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LOOKAHEAD_GAIN: r_gain = i_cfg_data[15:0];
                    CFG_LOOKAHEAD_BASE: r_base = i_cfg_data;
                    CFG_WHEELBASE:      r_wb = i_cfg_data;
                    CFG_STEER_LIMIT:    r_lim = i_cfg_data[13:0];
                    CFG_TOP_SPEED:      r_top = i_cfg_data[14:0];
                    CFG_SPEED_BLEND:    r_blend = i_cfg_data[16:0];
                    CFG_GOAL_RADIUS:    r_goal = i_cfg_data;
                    CFG_POINT_SPACING:  r_space = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                cmd_q.insert(cmd_q.size(), predict_cmd(t_req'(req_ch.req_type), req_ch.pos_x,
                                                       req_ch.pos_y, req_ch.heading,
                                                       req_ch.speed));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (cmd_q.size() == 0) begin
                    fail_n++;
                    $display("%0t: unexpected result status %0d", $time, res_ch.status);
                end else begin
                    want = cmd_q.pop_front();
                    if (want != {res_ch.status, res_ch.steer_cmd, res_ch.speed_cmd,
                                 res_ch.nearest_index, res_ch.aim_index,
                                 res_ch.path_length}) begin
                        fail_n++;
                        $display("%0t: exp %p got st %0d steer %0d spd %0d near %0d aim %0d len %0d",
                                 $time, want, res_ch.status, res_ch.steer_cmd,
                                 res_ch.speed_cmd, res_ch.nearest_index,
                                 res_ch.aim_index, res_ch.path_length);
                    end
                end
            end
        end
        o_pending <= cmd_q.size();
    end

endmodule

/* tb/sv/pure_pursuit_steering_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the pure-pursuit steering block: drives requests, configuration and
// result back-pressure, and gives the verdict. Depends on pps_pkg, the channel
// interfaces, pure_pursuit_steering and pps_tb_checker.
module pure_pursuit_steering_tb import pps_pkg::*; ;

    localparam int CYCLE_LIMIT = 3000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    bit                    idling_on = 1'b1;

    pps_req_if req_ch();
    pps_res_if res_ch();

    pure_pursuit_steering u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch),
        .o_res     (res_ch)
    );

    pps_tb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .req_ch      (req_ch),
        .res_ch      (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result back-pressure in random bursts.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // Present one request item and hold it until it is accepted.
    task automatic send_req(input t_req r, input int x, input int y, input int h,
                            input int s);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r;
        req_ch.pos_x <= x;
        req_ch.pos_y <= y;
        req_ch.heading <= h[15:0];
        req_ch.speed <= s[15:0];
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers while the block is idle.
    task automatic load_cfg(input int g, input int b, input int wb, input int lim,
                            input int top, input int bl, input int goal, input int sp);
        int vals[8];
        vals = '{g, b, wb, lim, top, bl, goal, sp};
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= t_cfg_idx'(i);
            cfg_data <= vals[i][22:0];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_heading();
        return int'($urandom_range(0, 51472)) - 25736;
    endfunction

    // Random part: mostly built paths followed by odometry near them, plus noise.
    task automatic run_random(input int n);
        int sent, bx, by, k, pick, spd;
        int wx[$], wy[$];
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 2) == 0 || wx.size() > 40) begin
                    send_req(REQ_CLEAR, $urandom, $urandom, rand_heading(), $urandom);
                    wx.delete();
                    wy.delete();
                    sent++;
                end
                bx = int'($urandom_range(0, 32'h3ff_ffff)) - 32'h200_0000;
                by = int'($urandom_range(0, 32'h3ff_ffff)) - 32'h200_0000;
                k = $urandom_range(2, 12);
                repeat (k) begin
                    bx += int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
                    by += int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
                    send_req(REQ_APPEND, bx, by, rand_heading(), $urandom);
                    wx.insert(wx.size(), bx);
                    wy.insert(wy.size(), by);
                    sent++;
                end
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, wx.size() - 1);
                    spd = ($urandom_range(0, 4) == 0) ? int'($urandom)
                                                      : int'($urandom_range(0, 1280)) - 256;
                    send_req(REQ_ODOM,
                             wx[pick] + int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000,
                             wy[pick] + int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000,
                             rand_heading(), spd);
                    sent++;
                end
            end else begin
                send_req(t_req'($urandom_range(0, 3)), $urandom, $urandom, rand_heading(),
                         $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NONE;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.heading = '0;
        req_ch.speed = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under reset configuration.
        send_req(REQ_ODOM, 0, 0, 0, 256);
        send_req(REQ_NONE, 32'h7fff_ffff, 32'h8000_0000, 25736, 32767);
        send_req(REQ_APPEND, 0, 0, 0, 0);
        send_req(REQ_APPEND, 100, 100, 0, 0);
        for (int i = 1; i <= 6; i++) send_req(REQ_APPEND, i * 65536, (i == 4) ? 65536 : 0, 0, 0);
        send_req(REQ_ODOM, 0, 0, 0, 256);
        send_req(REQ_ODOM, 6 * 65536, 0, 0, 256);
        send_req(REQ_ODOM, 2 * 65536, 65536, 25736, 32767);
        send_req(REQ_ODOM, 2 * 65536, -65536, -25736, -32768);
        send_req(REQ_ODOM, -3 * 65536, 0, 0, 0);
        send_req(REQ_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
        send_req(REQ_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_req(REQ_ODOM, 32'h8000_0000, 0, 12868, -256);
        send_req(REQ_CLEAR, 0, 0, 0, 0);
        send_req(REQ_ODOM, 0, 0, 0, 0);
        send_req(REQ_APPEND, -65536, -65536, 0, 0);
        send_req(REQ_ODOM, -65536, -65536, 0, 0);

        run_random(25);
        drain();

        // Upper extremes, blend weight above one.
        load_cfg(65535, 4194304, 4194304, 12868, 32767, 131071, 4194304, 4194304);
        run_random(20);
        drain();

        // Lower extremes: zero lookahead, wheelbase, limit, goal and spacing.
        load_cfg(0, 0, 0, 0, 0, 0, 0, 0);
        run_random(20);
        drain();

        // Mid settings.
        load_cfg(300, 40000, 150000, 9000, 1000, 65536, 20000, 30000);
        run_random(20);
        drain();

        // Last part without idling on either side.
        idling_on = 1'b0;
        load_cfg(26, 22938, 26214, 4817, 205, 52429, 32768, 6554);
        run_random(15);
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/pps_pkg.sv
rtl/pps_req_if.sv
rtl/pps_res_if.sv
rtl/pps_dp.sv
rtl/pps_ctrl.sv
rtl/pure_pursuit_steering.sv
tb/sv/pps_tb_checker.sv
tb/sv/pure_pursuit_steering_tb.sv
